### rtl/swse_pkg.sv
package swse_pkg;

   // Array sizing
   localparam int DEPTH         = 1024;
   localparam int ELEMENT_WIDTH = 32;
   localparam int ADDR_W        = $clog2(DEPTH);
   localparam int COUNT_W       = $clog2(DEPTH + 1);

   // Request and response field widths
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int START_W  = 10;
   localparam int STRIDE_W = 10;
   localparam int KCOUNT_W = 11;
   localparam int TOTAL_W  = 52;
   localparam int STATUS_W = 2;

   // Last index of a query: start + stride * (count - 1)
   localparam int LAST_W = STRIDE_W + KCOUNT_W + 1;
   // Element times weight
   localparam int PROD_W = ELEMENT_WIDTH + KCOUNT_W + 1;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Query handed to the walker
   typedef struct packed {
      logic [START_W-1:0]  start;
      logic [STRIDE_W-1:0] stride;
      logic [KCOUNT_W-1:0] count;
   } walk_cmd_type;

   // Element write port
   typedef struct packed {
      logic                     en;
      logic [ADDR_W-1:0]        addr;
      logic [ELEMENT_WIDTH-1:0] data;
   } mem_wr_type;

endpackage

### rtl/swse_walk.sv
module swse_walk
   import swse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  walk_cmd_type              cmd,
   input  mem_wr_type                wr,
   output logic                      done,
   output logic signed [TOTAL_W-1:0] total
);

   logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

   // Issue side
   logic                busy_ff, busy_in;
   logic [KCOUNT_W-1:0] left_ff, left_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]   step_ff;
   logic [KCOUNT_W-1:0] w_ff, w_in;
   logic                issue;

   // Read stage
   logic                            rd_v_ff;
   logic [KCOUNT_W-1:0]             rd_w_ff;
   logic signed [ELEMENT_WIDTH-1:0] rd_data_ff;

   // Multiply stage
   logic                     mul_v_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // Accumulator
   logic signed [TOTAL_W-1:0] acc_ff, acc_in;

   assign issue = busy_ff && (left_ff != '0);
   assign done  = busy_ff && (left_ff == '0) && !rd_v_ff && !mul_v_ff;
   assign total = acc_ff;

   // Walk sequencer: one element address per cycle
   always_comb begin
      busy_in = busy_ff;
      left_in = left_ff;
      idx_in  = idx_ff;
      w_in    = w_ff;
      if (start) begin
         busy_in = 1'b1;
         left_in = cmd.count;
         idx_in  = ADDR_W'(cmd.start);
         w_in    = KCOUNT_W'(1);
      end else if (issue) begin
         left_in = left_ff - KCOUNT_W'(1);
         idx_in  = idx_ff + step_ff;
         w_in    = w_ff + KCOUNT_W'(1);
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   // Shared multiplier and accumulator
   assign prod_in = $signed(rd_data_ff) * $signed({1'b0, rd_w_ff});

   always_comb begin
      acc_in = acc_ff;
      if (start) begin
         acc_in = '0;
      end else if (mul_v_ff) begin
         acc_in = acc_ff + TOTAL_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         left_ff  <= '0;
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         left_ff  <= left_in;
         rd_v_ff  <= issue;
         mul_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      w_ff    <= w_in;
      rd_w_ff <= w_ff;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (start) begin
         step_ff <= ADDR_W'(cmd.stride);
      end
   end

   // Element memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[idx_ff];
   end

endmodule

### rtl/strided_weighted_sum_engine.sv
// Strided weighted sum engine.
// Request channel (req_valid/req_ready) carries an action: clear the array,
// append req_value at the next free index, or query start req_start_req,
// stride req_stride and count req_count, giving A[l]*1 + A[l+d]*2 + ...
// Response channel (rsp_valid/rsp_ready) returns one rsp_total/rsp_status
// per request: ok, query out of range, or array full on append.
// Clear and append: the request goes to the done state, and its response is
// then loaded into the output register. Query: the range check runs in the
// MULT and TEST states, then the walker reads one element per cycle through
// the single memory read port and one shared multiplier, and the read, multiply and accumulate stages drain.
// Rejected queries go from TEST to the done state. One request is in work at a time;
// req_ready is high whenever the engine is idle.
// A finished response sits in the output register; the next request may be
// accepted while it waits, and its own result is held until rsp_ready
// frees the output register.
// Reset (synchronous, active high) empties the array and drops any
// pending response; array contents are not cleared.
module strided_weighted_sum_engine
   import swse_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [START_W-1:0]         req_start_req,
   input  logic [STRIDE_W-1:0]        req_stride,
   input  logic [KCOUNT_W-1:0]        req_count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [TOTAL_W-1:0]  rsp_total,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MULT = 3'd1;
   localparam logic [2:0] ST_TEST = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   walk_cmd_type              cmd_ff, cmd_in;
   logic [LAST_W-1:0]         last_ff, last_in;
   logic                      bad_ff, bad_in;
   logic signed [TOTAL_W-1:0] res_total_ff, res_total_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic                      accept;
   logic                      full;
   logic                      ld_rsp;
   logic                      walk_start;
   logic                      walk_done;
   logic signed [TOTAL_W-1:0] walk_total;
   mem_wr_type                wr;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign ld_rsp     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign walk_start = (state_ff == ST_TEST) && !bad_ff && (last_ff < LAST_W'(count_ff));

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_total  = rsp_total_ff;
   assign rsp_status = rsp_status_ff;

   // Append write
   always_comb begin
      wr.en   = accept && (req_action == ACT_APPEND) && !full;
      wr.addr = count_ff[ADDR_W-1:0];
      wr.data = ELEMENT_WIDTH'(req_value);
   end

   // Request sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      last_in       = last_ff;
      bad_in        = bad_ff;
      res_total_in  = res_total_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_total_in  = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
               case (req_action)
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_APPEND: begin
                     if (full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
                  ACT_QUERY: begin
                     cmd_in.start  = req_start_req;
                     cmd_in.stride = req_stride;
                     cmd_in.count  = req_count;
                     state_in      = ST_MULT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MULT: begin
            // last index reached by the query
            last_in = LAST_W'(cmd_ff.start)
                    + LAST_W'(cmd_ff.stride) * LAST_W'(cmd_ff.count - KCOUNT_W'(1));
            bad_in  = (cmd_ff.stride == '0) || (cmd_ff.count == '0);
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (walk_start) begin
               state_in = ST_WALK;
            end else begin
               res_status_in = STATUS_RANGE;
               state_in      = ST_DONE;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               res_total_in = walk_total;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ld_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      if (ld_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_total_in  = res_total_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      last_ff       <= last_in;
      bad_ff        <= bad_in;
      res_total_ff  <= res_total_in;
      res_status_ff <= res_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   swse_walk u_walk (
      .clock (clock),
      .reset (reset),
      .start (walk_start),
      .cmd   (cmd_ff),
      .wr    (wr),
      .done  (walk_done),
      .total (walk_total)
   );

   // Checks
   a_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_done |-> (state_ff == ST_WALK))
      else $error("walker finished outside a query walk");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("loaded count beyond array depth");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      walk_start |-> (!bad_ff && (last_ff < LAST_W'(count_ff)) && (count_ff != '0)))
      else $error("walk started on a rejected query");

   a_full_append: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_APPEND) && full) |=>
         ((res_status_ff == STATUS_FULL) && (count_ff == $past(count_ff))))
      else $error("append on a full array not rejected");

endmodule

### tb/tb_strided_weighted_sum_engine.sv
`timescale 1ns / 100ps

module tb_strided_weighted_sum_engine;
   import swse_pkg::*;

   // Action code that the block answers without any state change
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   // Cycles without any request or response moving before the run is called hung
   localparam int unsigned WATCHDOG_LIMIT = 20000;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PATTERN} ready_mode_type;

   // Tracks the array contents and the sums that the block owes us
   class weighted_sum_scoreboard;
      typedef struct {
         logic signed [TOTAL_W-1:0] total;
         logic [STATUS_W-1:0]       status;
      } sum_result_type;

      logic signed [ELEMENT_WIDTH-1:0] elements [DEPTH];
      int unsigned                     loaded_count = 0;
      sum_result_type                  pending_sums [$];
      int unsigned                     mismatches = 0;

      // Update the array image for one accepted request and queue its result
      function void apply_request(logic [ACTION_W-1:0] action,
                                  logic signed [VALUE_W-1:0] value,
                                  logic [START_W-1:0] start,
                                  logic [STRIDE_W-1:0] stride,
                                  logic [KCOUNT_W-1:0] count);
         sum_result_type res;
         longint         acc;
         longint         last_idx;
         longint         widened;
         int unsigned    idx;
         res.total  = '0;
         res.status = STATUS_OK;
         case (action)
            ACT_CLEAR: loaded_count = 0;
            ACT_APPEND: begin
               if (loaded_count >= DEPTH) begin
                  res.status = STATUS_FULL;
               end else begin
                  // sign-extend, then keep the element width
                  widened = longint'(value);
                  elements[loaded_count] = widened[ELEMENT_WIDTH-1:0];
                  loaded_count++;
               end
            end
            ACT_QUERY: begin
               if (stride == 0 || count == 0) begin
                  res.status = STATUS_RANGE;
               end else begin
                  last_idx = longint'(start) + longint'(stride) * (longint'(count) - 1);
                  if (last_idx >= loaded_count) begin
                     res.status = STATUS_RANGE;
                  end else begin
                     acc = 0;
                     idx = 32'(start);
                     for (int w = 1; w <= int'(count); w++) begin
                        acc += longint'(elements[idx]) * longint'(w);
                        idx += 32'(stride);
                     end
                     res.total = acc[TOTAL_W-1:0];
                  end
               end
            end
            default: ;  // unused code: no state change
         endcase
         pending_sums.push_back(res);
      endfunction

      // Compare one accepted response with the oldest pending sum
      function void check_response(logic signed [TOTAL_W-1:0] total,
                                   logic [STATUS_W-1:0] status);
         sum_result_type exp_res;
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: total %0d status %0d", total, status);
            return;
         end
         exp_res = pending_sums.pop_front();
         if (total !== exp_res.total) begin
            mismatches++;
            if (mismatches <= 10)
               $display("total mismatch: expected %0d, got %0d", exp_res.total, total);
         end
         if (status !== exp_res.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("status mismatch: expected %0d, got %0d", exp_res.status, status);
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [ACTION_W-1:0]        req_action = ACT_CLEAR;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic [START_W-1:0]         req_start_req = '0;
   logic [STRIDE_W-1:0]        req_stride = '0;
   logic [KCOUNT_W-1:0]        req_count = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [TOTAL_W-1:0]  rsp_total;
   logic [STATUS_W-1:0]        rsp_status;

   weighted_sum_scoreboard sb = new();

   int unsigned    burst_left = 0;
   int unsigned    idle_cycles = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int unsigned    ready_left = 0;
   logic [7:0]     ready_pattern = 8'hff;

   strided_weighted_sum_engine u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_value     (req_value),
      .req_start_req (req_start_req),
      .req_stride    (req_stride),
      .req_count     (req_count),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_total     (rsp_total),
      .rsp_status    (rsp_status)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Receiver back-pressure: random modes, each held until ready_left runs out
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode    = ready_mode_type'($urandom_range(0, 3));
         ready_left    = $urandom_range(10, 150);
         ready_pattern = 8'($urandom);
      end else begin
         ready_left = ready_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS:  rsp_ready = 1'b1;
         READY_COIN:    rsp_ready = ($urandom_range(0, 1) == 1);
         READY_SPARSE:  rsp_ready = ($urandom_range(0, 7) == 0);
         default:       rsp_ready = ready_pattern[ready_left[2:0]];
      endcase
   end

   // Response checking and hang detection
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_total, rsp_status);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Sender pacing: bursts of back-to-back requests, then a gap
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         @(negedge clock) req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Present one request and hold it until accepted
   task automatic send_request(logic [ACTION_W-1:0] action,
                               logic signed [VALUE_W-1:0] value,
                               logic [START_W-1:0] start,
                               logic [STRIDE_W-1:0] stride,
                               logic [KCOUNT_W-1:0] count);
      @(negedge clock);
      req_valid     = 1'b1;
      req_action    = action;
      req_value     = value;
      req_start_req = start;
      req_stride    = stride;
      req_count     = count;
      do @(posedge clock); while (!req_ready);
      sb.apply_request(action, value, start, stride, count);
      pace_sender();
   endtask

   // Element values lean toward the extremes
   function automatic logic signed [VALUE_W-1:0] random_element();
      case ($urandom_range(0, 9))
         0:       return {1'b0, {(VALUE_W-1){1'b1}}};
         1:       return {1'b1, {(VALUE_W-1){1'b0}}};
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // Query that stays inside the loaded elements
   task automatic send_valid_query();
      int unsigned n;
      int unsigned kmax;
      int unsigned k;
      int unsigned d;
      int unsigned l;
      n    = sb.loaded_count;
      kmax = ($urandom_range(0, 14) == 0 || n < 32) ? n : 32;
      k    = $urandom_range(1, kmax);
      if (k == 1)
         d = $urandom_range(1, 1023);
      else
         d = $urandom_range(1, (n - 1) / (k - 1));
      l = $urandom_range(0, n - 1 - d * (k - 1));
      send_request(ACT_QUERY, random_element(), START_W'(l), STRIDE_W'(d), KCOUNT_W'(k));
   endtask

   // Query that must be rejected
   task automatic send_bad_query();
      int unsigned low_start;
      low_start = (sb.loaded_count > 1023) ? 1023 : sb.loaded_count;
      case ($urandom_range(0, 3))
         0: send_request(ACT_QUERY, $urandom, START_W'($urandom), '0,
                         KCOUNT_W'($urandom_range(0, 2047)));
         1: send_request(ACT_QUERY, $urandom, START_W'($urandom),
                         STRIDE_W'($urandom_range(1, 1023)), '0);
         2: send_request(ACT_QUERY, $urandom, START_W'($urandom),
                         STRIDE_W'($urandom_range(1, 1023)),
                         KCOUNT_W'($urandom_range(1025, 2047)));
         default: send_request(ACT_QUERY, $urandom, START_W'($urandom_range(low_start, 1023)),
                               STRIDE_W'($urandom_range(1, 1023)),
                               KCOUNT_W'($urandom_range(1, 4)));
      endcase
   endtask

   // Mostly appends and in-range queries, with clears, rejects and noise
   task automatic run_random(int unsigned target);
      int unsigned done_items;
      int unsigned pick;
      done_items = 0;
      while (done_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 2 || sb.loaded_count >= 240) begin
            send_request(ACT_CLEAR, $urandom, START_W'($urandom), STRIDE_W'($urandom),
                         KCOUNT_W'($urandom));
         end else if (pick < 45 || sb.loaded_count == 0) begin
            send_request(ACT_APPEND, random_element(), START_W'($urandom),
                         STRIDE_W'($urandom), KCOUNT_W'($urandom));
         end else if (pick < 85) begin
            send_valid_query();
         end else if (pick < 93) begin
            send_bad_query();
         end else if (pick < 96) begin
            // no state change in the block, so not counted
            send_request(ACT_UNUSED, $urandom, START_W'($urandom), STRIDE_W'($urandom),
                         KCOUNT_W'($urandom));
            continue;
         end else begin
            send_request(ACTION_W'($urandom_range(0, 2)), $urandom, START_W'($urandom),
                         STRIDE_W'($urandom), KCOUNT_W'($urandom));
         end
         done_items++;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Directed: empty array, extremes, each query reject reason, unused code
      send_request(ACT_QUERY, '0, 0, 1, 1);
      send_request(ACT_CLEAR, '0, 0, 0, 0);
      send_request(ACT_APPEND, {1'b0, {(VALUE_W-1){1'b1}}}, 0, 0, 0);
      send_request(ACT_APPEND, {1'b1, {(VALUE_W-1){1'b0}}}, 0, 0, 0);
      send_request(ACT_APPEND, '0, '1, '1, '1);
      send_request(ACT_APPEND, '1, 0, 0, 0);
      send_request(ACT_APPEND, 12345, 0, 0, 0);
      send_request(ACT_QUERY, '0, 0, 1, 5);
      send_request(ACT_QUERY, '1, 0, 2, 3);
      send_request(ACT_QUERY, '0, 4, 1023, 1);
      send_request(ACT_QUERY, '0, 0, 0, 3);
      send_request(ACT_QUERY, '0, 0, 1, 0);
      send_request(ACT_QUERY, '0, 1023, 1, 1);
      send_request(ACT_QUERY, '0, 0, 1, 6);
      send_request(ACT_QUERY, '1, 1023, 1023, 2047);
      send_request(ACT_UNUSED, '1, '1, '1, '1);
      send_request(ACT_CLEAR, '1, '1, '1, '1);
      send_request(ACT_QUERY, '0, 0, 1, 1);

      run_random(560);

      // Drain
      @(negedge clock) req_valid = 1'b0;
      while (sb.pending_sums.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
